// File: rtl/dwps_pkg.sv
// Package for the disc window pixel scanner.
// Holds the beat structs, action and register codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package dwps_pkg;

	localparam int COORD_W    = 8;
	localparam int COLOR_W    = 16;
	localparam int RADIUS_W   = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int PANEL_SIZE_DEFAULT = 240;

	// Item actions
	localparam logic ACTION_START   = 1'b0;
	localparam logic ACTION_ADVANCE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COVER_MODE       = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_COLOR = 1'd1;

	typedef struct packed {
		logic                action;
		logic [COORD_W-1:0]  center_x;
		logic [COORD_W-1:0]  center_y;
		logic [RADIUS_W-1:0] radius_q4;
		logic [COLOR_W-1:0]  draw_color;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               write_pixel;
		logic               scan_done;
	} pixel_t;

endpackage

// File: rtl/disc_window_pixel_scanner.sv
// Disc window pixel scanner: walks the bounding window of a disc and
// emits one pixel beat per advance item. Depends on dwps_pkg.
`timescale 1ns / 1ps

// Usage
//   Item channel (item_valid / item_stall / item): a start beat loads a disc
//   (center, radius in unsigned Q4, color) and yields no pixel beat. An
//   advance beat visits the next position of the clipped window in
//   row-major order and yields exactly one pixel beat on the pixel channel
//   (pixel_valid / pixel_stall / pixel). An advance with no active window
//   yields an all-zero beat with scan_done set.
//   Configuration (cfg_write / cfg_index / cfg_data): cover_mode and
//   background_color; the user must write them only while the block is idle (the block does not enforce it).
// Pipeline
//   An accepted advance is registered in the middle stage and then in the
//   output register before it is presented on the pixel channel.
//   One item per clock sustained unless the pixel channel stalls: the window
//   counters step per advance, the squared-distance compare sits in the next stage.
// Reset
//   arst_n clears the scan state, both configuration registers and the
//   pipeline valids; no window is active afterwards.
// Stall
//   A stalled pixel beat holds in the output register. The middle stage
//   still fills, so item_stall rises only when both stages hold beats.
module disc_window_pixel_scanner #(
	parameter int PANEL_SIZE = dwps_pkg::PANEL_SIZE_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  dwps_pkg::item_t                    item,
	output logic                               pixel_valid,
	input  logic                               pixel_stall,
	output dwps_pkg::pixel_t                   pixel,
	input  logic                               cfg_write,
	input  logic [dwps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dwps_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dwps_pkg::*;

	// Largest coordinate on the panel, one bit wider than a coordinate so
	// the unclipped upper limit compares cleanly.
	localparam logic [COORD_W:0] PANEL_MAX = (COORD_W+1)'(PANEL_SIZE - 1);

	typedef struct packed {
		logic [COORD_W-1:0] lo;
		logic [COORD_W:0]   hi;
	} axis_t;

	typedef struct packed {
		logic                      live;
		logic [COORD_W-1:0]        x;
		logic [COORD_W-1:0]        y;
		logic signed [COORD_W:0]   dx;
		logic signed [COORD_W:0]   dy;
		logic [COLOR_W-1:0]        rsq;
		logic [COLOR_W-1:0]        color;
		logic                      done;
	} visit_t;

	// Window limits on one axis: floor(c - r + 1/2) and floor(c + r + 1/2),
	// low end clamped at zero, high end clipped to the panel.
	function automatic axis_t axis_window(input logic [COORD_W-1:0] center,
	                                      input logic [RADIUS_W-1:0] rq);
		logic [RADIUS_W-1:0] c16;
		logic [RADIUS_W+1:0] lo_sum;
		logic [RADIUS_W:0]   hi_sum;
		axis_t               w;
		c16    = {center, 4'b0000};
		lo_sum = {2'b00, c16} + (RADIUS_W+2)'(8) - {2'b00, rq};
		hi_sum = {1'b0, c16} + {1'b0, rq} + (RADIUS_W+1)'(8);
		w.lo   = lo_sum[RADIUS_W+1] ? '0 : lo_sum[RADIUS_W-1:4];
		w.hi   = (hi_sum[RADIUS_W:4] > PANEL_MAX) ? PANEL_MAX : hi_sum[RADIUS_W:4];
		return w;
	endfunction

	// Configuration
	logic               cover_mode_q;
	logic [COLOR_W-1:0] background_color_q;

	// Scan state
	logic [COORD_W-1:0] scan_column_q;
	logic [COORD_W-1:0] scan_row_q;
	logic [COORD_W-1:0] window_left_q;
	logic [COORD_W-1:0] window_right_q;
	logic [COORD_W-1:0] window_bottom_q;
	logic [COORD_W-1:0] disc_center_x_q;
	logic [COORD_W-1:0] disc_center_y_q;
	logic [COLOR_W-1:0] radius_squared_q;
	logic [COLOR_W-1:0] disc_color_q;
	logic               scan_active_q;

	// Pipeline
	logic   s1_valid;
	visit_t s1;
	logic   pipe_en;
	logic   item_take;

	// Start-side arithmetic
	axis_t                 win_x;
	axis_t                 win_y;
	logic [2*RADIUS_W-1:0] r2;
	logic [2*RADIUS_W:0]   r2_round;
	logic                  win_empty;

	// Advance-side stepping
	logic   last_col;
	logic   last_row;
	visit_t visit_next;

	// Distance compare
	logic signed [2*COORD_W+1:0] dx_sq;
	logic signed [2*COORD_W+1:0] dy_sq;
	logic [COLOR_W:0]            d2;
	logic                        in_disc;
	pixel_t                      pixel_next;

	// The output register moves when empty or taken; the middle stage
	// moves whenever it is empty or the output register moves.
	assign pipe_en    = !pixel_valid || !pixel_stall;
	assign item_stall = s1_valid && !pipe_en;
	assign item_take  = item_valid && !item_stall;

	always_comb begin
		win_x     = axis_window(item.center_x, item.radius_q4);
		win_y     = axis_window(item.center_y, item.radius_q4);
		r2        = item.radius_q4 * item.radius_q4;
		r2_round  = {1'b0, r2} + (2*RADIUS_W+1)'(128);
		win_empty = ({1'b0, win_x.lo} > win_x.hi) || ({1'b0, win_y.lo} > win_y.hi);
	end

	always_comb begin
		last_col = scan_column_q >= window_right_q;
		last_row = scan_row_q >= window_bottom_q;

		visit_next.live  = scan_active_q;
		visit_next.x     = scan_column_q;
		visit_next.y     = scan_row_q;
		visit_next.dx    = $signed({1'b0, scan_column_q}) - $signed({1'b0, disc_center_x_q});
		visit_next.dy    = $signed({1'b0, scan_row_q}) - $signed({1'b0, disc_center_y_q});
		visit_next.rsq   = radius_squared_q;
		visit_next.color = disc_color_q;
		visit_next.done  = last_col && last_row;
		// Idle advance: blank position, flagged done
		if (!scan_active_q) begin
			visit_next.x    = '0;
			visit_next.y    = '0;
			visit_next.done = 1'b1;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cover_mode_q       <= 1'b0;
			background_color_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_COVER_MODE:       cover_mode_q       <= cfg_data[0];
				CFG_BACKGROUND_COLOR: background_color_q <= cfg_data[COLOR_W-1:0];
			endcase
		end
	end

	// Scan state: load on start, step on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_column_q    <= '0;
			scan_row_q       <= '0;
			window_left_q    <= '0;
			window_right_q   <= '0;
			window_bottom_q  <= '0;
			disc_center_x_q  <= '0;
			disc_center_y_q  <= '0;
			radius_squared_q <= '0;
			disc_color_q     <= '0;
			scan_active_q    <= 1'b0;
		end else if (item_take) begin
			if (item.action == ACTION_START) begin
				disc_center_x_q  <= item.center_x;
				disc_center_y_q  <= item.center_y;
				radius_squared_q <= r2_round[2*RADIUS_W-1:8];
				disc_color_q     <= item.draw_color;
				// Empty window: stay idle, keep old limits
				scan_active_q    <= !win_empty;
				if (!win_empty) begin
					window_left_q   <= win_x.lo;
					window_right_q  <= win_x.hi[COORD_W-1:0];
					window_bottom_q <= win_y.hi[COORD_W-1:0];
					scan_column_q   <= win_x.lo;
					scan_row_q      <= win_y.lo;
				end
			end else if (scan_active_q) begin
				if (last_col) begin
					if (last_row) begin
						scan_active_q <= 1'b0;
					end else begin
						scan_row_q    <= scan_row_q + 1'b1;
						scan_column_q <= window_left_q;
					end
				end else begin
					scan_column_q <= scan_column_q + 1'b1;
				end
			end
		end
	end

	// Middle stage: visited position and its offsets from the center
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!s1_valid || pipe_en) begin
			s1_valid <= item_take && (item.action == ACTION_ADVANCE);
		end
	end

	always_ff @(posedge clk) begin
		if (item_take && (!s1_valid || pipe_en)) begin
			s1 <= visit_next;
		end
	end

	// Squared distance against the rounded squared radius
	always_comb begin
		dx_sq   = s1.dx * s1.dx;
		dy_sq   = s1.dy * s1.dy;
		d2      = {1'b0, dx_sq[COLOR_W-1:0]} + {1'b0, dy_sq[COLOR_W-1:0]};
		in_disc = d2 <= {1'b0, s1.rsq};

		pixel_next.pixel_x     = s1.x;
		pixel_next.pixel_y     = s1.y;
		pixel_next.scan_done   = s1.done;
		pixel_next.pixel_color = '0;
		pixel_next.write_pixel = 1'b0;
		if (s1.live) begin
			if (in_disc) begin
				pixel_next.pixel_color = s1.color;
				pixel_next.write_pixel = 1'b1;
			end else if (cover_mode_q) begin
				pixel_next.pixel_color = background_color_q;
				pixel_next.write_pixel = 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
		end else if (pipe_en) begin
			pixel_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en && s1_valid) begin
			pixel <= pixel_next;
		end
	end

	// Checks
	a_scan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		scan_active_q |-> (scan_column_q <= window_right_q) &&
		                  (scan_row_q <= window_bottom_q))
		else $error("scan position beyond window");

	a_window_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		scan_active_q |-> (window_left_q <= window_right_q) &&
		                  (scan_column_q >= window_left_q))
		else $error("window left above right");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && (item.action == ACTION_ADVANCE)) |=> s1_valid)
		else $error("accepted advance lost before middle stage");

	a_blank_color: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel.write_pixel) |-> (pixel.pixel_color == '0))
		else $error("unwritten pixel carries a color");

endmodule

// File: test/disc_window_pixel_scanner_tb.sv
// Testbench for disc_window_pixel_scanner: random and directed disc scans
// checked beat by beat against a scoreboard that tracks the window walk.
// Depends on dwps_pkg and the scanner RTL only.
`timescale 1ns / 1ps

import dwps_pkg::*;

class pixel_scoreboard;
	bit        cover_on;
	bit [15:0] backdrop;
	bit [7:0]  col, row, left, right, bottom, cx, cy;
	bit [15:0] r_sq, disc_color;
	bit        active;
	pixel_t    pixels_due[$];
	int        errors;

	task report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (errors <= 40) begin
			$display("%0t: %s: got %0h, want %0h", $time, what, got, want);
		end
	endtask

	function void write_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
		if (idx == CFG_COVER_MODE) begin
			cover_on = data[0];
		end else if (idx == CFG_BACKGROUND_COLOR) begin
			backdrop = data;
		end
	endfunction

	// Window span on one axis: round both edges half up, clip to the panel.
	function void axis_span(int c, int rq, output int lo, output int hi);
		int a;
		int b;
		a = c * 16 - rq + 8;
		b = c * 16 + rq + 8;
		lo = (a < 0) ? 0 : a / 16;
		hi = b / 16;
		if (hi > PANEL_SIZE_DEFAULT - 1) begin
			hi = PANEL_SIZE_DEFAULT - 1;
		end
	endfunction

	// Positions still to visit in the current window, row-major.
	function int pixels_left();
		if (!active) begin
			return 0;
		end
		return (int'(right) - int'(left) + 1) * (int'(bottom) - int'(row))
			+ int'(right) - int'(col) + 1;
	endfunction

	function void note_item(item_t it);
		int xl, xh, yl, yh, dx, dy, d2;
		int unsigned rr;
		pixel_t px;
		if (it.action == ACTION_START) begin
			axis_span(int'(it.center_x), int'(it.radius_q4), xl, xh);
			axis_span(int'(it.center_y), int'(it.radius_q4), yl, yh);
			cx = it.center_x;
			cy = it.center_y;
			rr = int'(it.radius_q4);
			rr = rr * rr;
			r_sq = 16'((rr + 128) >> 8);
			disc_color = it.draw_color;
			active = (xl <= xh) && (yl <= yh);
			if (active) begin
				left   = 8'(xl);
				right  = 8'(xh);
				bottom = 8'(yh);
				col    = 8'(xl);
				row    = 8'(yl);
			end
			return;
		end
		px = '0;
		if (!active) begin
			px.scan_done = 1'b1;
		end else begin
			dx = int'(col) - int'(cx);
			dy = int'(row) - int'(cy);
			d2 = dx * dx + dy * dy;
			px.pixel_x = col;
			px.pixel_y = row;
			if (d2 <= int'(r_sq)) begin
				px.pixel_color = disc_color;
				px.write_pixel = 1'b1;
			end else if (cover_on) begin
				px.pixel_color = backdrop;
				px.write_pixel = 1'b1;
			end
			if (col >= right) begin
				if (row >= bottom) begin
					px.scan_done = 1'b1;
					active = 1'b0;
				end else begin
					row = row + 8'd1;
					col = left;
				end
			end else begin
				col = col + 8'd1;
			end
		end
		pixels_due.push_back(px);
	endfunction

	task check_pixel(pixel_t got);
		pixel_t want;
		if (pixels_due.size() == 0) begin
			report("pixel beat with nothing expected, x", got.pixel_x, 0);
			return;
		end
		want = pixels_due.pop_front();
		if (got.pixel_x !== want.pixel_x)
			report("pixel_x", got.pixel_x, want.pixel_x);
		if (got.pixel_y !== want.pixel_y)
			report("pixel_y", got.pixel_y, want.pixel_y);
		if (got.pixel_color !== want.pixel_color)
			report("pixel_color", got.pixel_color, want.pixel_color);
		if (got.write_pixel !== want.write_pixel)
			report("write_pixel", got.write_pixel, want.write_pixel);
		if (got.scan_done !== want.scan_done)
			report("scan_done", got.scan_done, want.scan_done);
	endtask
endclass

module disc_window_pixel_scanner_tb;

	localparam int PANEL           = PANEL_SIZE_DEFAULT;
	localparam int ITEMS_PER_PHASE = 145;
	// A start leaves no beat, so allow margin for the pipeline to settle.
	localparam int SETTLE          = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item;
	logic                  pixel_valid;
	logic                  pixel_stall;
	pixel_t                pixel;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Percentage of cycles in which each side holds off; zero for a quiet stretch.
	int idle_pct = 22;

	pixel_scoreboard board;

	disc_window_pixel_scanner #(
		.PANEL_SIZE(PANEL)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel      (pixel),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case a beat never shows up.
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Pixel side: check the beat taken at this edge (pre-edge values), then
	// pick the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && pixel_valid && !pixel_stall) begin
			board.check_pixel(pixel);
		end
		pixel_stall <= ($urandom_range(0, 99) < idle_pct);
	end

	function automatic item_t start_beat(logic [7:0] x, logic [7:0] y,
		logic [11:0] rq, logic [15:0] shade);
		item_t it;
		it.action     = ACTION_START;
		it.center_x   = x;
		it.center_y   = y;
		it.radius_q4  = rq;
		it.draw_color = shade;
		return it;
	endfunction

	// Fill every field at random; the start-only fields ride along as junk
	// on advance beats.
	function automatic item_t random_beat(logic act);
		item_t it;
		it.action     = act;
		it.center_x   = 8'($urandom);
		it.center_y   = 8'($urandom);
		it.radius_q4  = 12'($urandom);
		it.draw_color = 16'($urandom);
		return it;
	endfunction

	// Mostly on-panel centers, with the panel edges and the off-panel
	// codes mixed in.
	function automatic logic [7:0] pick_center();
		case ($urandom_range(0, 9))
			0: begin
				return 8'd0;
			end
			1: begin
				return 8'(PANEL - 1);
			end
			2: begin
				return 8'($urandom_range(PANEL, 255));
			end
			default: begin
				return 8'($urandom_range(0, PANEL - 1));
			end
		endcase
	endfunction

	// Present one item beat, idling at random first; hold the payload
	// until the edge where stall is low, then note it.
	task automatic send_item(item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		board.note_item(it);
	endtask

	task automatic advance(int n);
		repeat (n) send_item(random_beat(ACTION_ADVANCE));
	endtask

	// Drop valid and wait for every expected pixel, then let any start
	// still in flight settle.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (board.pixels_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write both registers back to back; the enable stays high across them.
	task automatic load_registers(logic cover_on, logic [15:0] backdrop);
		cfg_write <= 1'b1;
		cfg_index <= CFG_COVER_MODE;
		cfg_data  <= {15'd0, cover_on};
		@(posedge clk);
		board.write_register(CFG_COVER_MODE, {15'd0, cover_on});
		cfg_index <= CFG_BACKGROUND_COLOR;
		cfg_data  <= backdrop;
		@(posedge clk);
		board.write_register(CFG_BACKGROUND_COLOR, backdrop);
		cfg_write <= 1'b0;
	endtask

	// Mostly complete scans of small discs with random content, plus cut-off
	// scans of any disc and lone random beats.
	task automatic random_traffic(int budget);
		int sent;
		int pick;
		int n;
		logic [11:0] rq;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				rq = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 72))
					: 12'($urandom_range(0, 40));
				send_item(start_beat(pick_center(), pick_center(), rq, 16'($urandom)));
				// Walk the whole window, sometimes one step past its end.
				n = board.pixels_left() + (($urandom_range(0, 3) == 0) ? 1 : 0);
				advance(n);
				sent += n + 1;
			end else if (pick < 85) begin
				send_item(random_beat(ACTION_START));
				n = $urandom_range(0, 12);
				advance(n);
				sent += n + 1;
			end else begin
				send_item(random_beat(1'($urandom_range(0, 1))));
				sent++;
			end
		end
	endtask

	initial begin
		board       = new();
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item        = '0;
		pixel_stall = 1'b0;
		cfg_write   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, registers at their reset values.
		// Advance with no window: all-zero beat with scan_done.
		advance(1);
		// Zero radius at the origin: one inside pixel, then idle again.
		send_item(start_beat(8'd0, 8'd0, 12'd0, 16'hFFFF));
		advance(2);
		// Center beyond the panel: window clips to nothing, stays idle.
		send_item(start_beat(8'd255, 8'd255, 12'd0, 16'h1234));
		advance(1);
		// Bottom-right corner, window clipped to two by two.
		send_item(start_beat(8'(PANEL - 1), 8'(PANEL - 1), 12'd24, 16'h0000));
		advance(4);
		// Largest radius, cut short by a new start in mid-scan.
		send_item(start_beat(8'd0, 8'd0, 12'd4095, 16'hA5A5));
		advance(3);
		// Three by three window whose corners fall outside the disc.
		send_item(start_beat(8'd120, 8'd120, 12'd18, 16'h5A5A));
		advance(9);

		// Cover mode with white background, no idling on either side.
		drain();
		idle_pct = 0;
		load_registers(1'b1, 16'hFFFF);
		random_traffic(ITEMS_PER_PHASE);

		drain();
		idle_pct = 22;
		load_registers(1'b0, 16'($urandom));
		random_traffic(ITEMS_PER_PHASE);

		drain();
		load_registers(1'b1, 16'h0000);
		random_traffic(ITEMS_PER_PHASE);

		drain();
		load_registers(1'b1, 16'($urandom));
		random_traffic(ITEMS_PER_PHASE);

		drain();
		if (board.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
